[rtl/core/polar_scan_binner_macros.svh]
// Assertion macros for the polar scan binner RTL.
// Used by psb_ctrl and psb_dp; expects clk and rst_n in scope.
`ifndef POLAR_SCAN_BINNER_MACROS_SVH
`define POLAR_SCAN_BINNER_MACROS_SVH
`ifndef SYNTHESIS
`define PSB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("psb assertion failed");
`define PSB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psb assertion failed");
`else
`define PSB_ASSERT(lbl, prop)
`define PSB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/core/psb_pkg.sv]
// Shared types, constants and tables of the polar scan binner.
// No dependencies.
`timescale 1ns / 1ps
package psb_pkg;

  localparam int NUM_BINS     = 720;
  localparam int BIN_AW       = $clog2(NUM_BINS);
  localparam int CNT_W        = (BIN_AW > 5) ? BIN_AW : 5;
  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 28;

  localparam logic [23:0] EMPTY_RANGE = 24'hFFFFFF;
  localparam logic [27:0] RANGE_LO    = 28'd1966;
  localparam logic [27:0] RANGE_HI    = 28'd655360;
  localparam logic signed [33:0] HALF_TURN = 34'sh080000000;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [7:0] CFG_ROT_COS  = 8'd0;
  localparam logic [7:0] CFG_ROT_SIN  = 8'd1;
  localparam logic [7:0] CFG_OFFSET_X = 8'd2;
  localparam logic [7:0] CFG_OFFSET_Y = 8'd3;

  typedef struct packed {
    logic              operation;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic [9:0]        bin_index;
  } in_item_t;

  typedef struct packed {
    logic [23:0] bin_range;
    logic        bin_hit;
  } out_item_t;

  typedef struct packed {
    logic             clear;
    logic             load_in;
    logic             mul;
    logic             fin;
    logic             sq;
    logic             iter;
    logic             bin;
    logic             mem_rd;
    logic             rd_sel;
    logic             upd;
    logic             rd_done;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic out_busy;
  } status_t;

  function automatic logic signed [33:0] atan_lut(input logic [3:0] i);
    logic signed [33:0] v;
    unique case (i)
      4'd0:  v = 34'sd536870912;
      4'd1:  v = 34'sd316933406;
      4'd2:  v = 34'sd167458907;
      4'd3:  v = 34'sd85004756;
      4'd4:  v = 34'sd42667331;
      4'd5:  v = 34'sd21354465;
      4'd6:  v = 34'sd10679838;
      4'd7:  v = 34'sd5340245;
      4'd8:  v = 34'sd2670163;
      4'd9:  v = 34'sd1335087;
      4'd10: v = 34'sd667544;
      4'd11: v = 34'sd333772;
      4'd12: v = 34'sd166886;
      4'd13: v = 34'sd83443;
      4'd14: v = 34'sd41722;
      default: v = 34'sd20861;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/psb_ctrl.sv]
// Sequencer of the polar scan binner: clear pass, add and read sequences.
// Depends on psb_pkg and polar_scan_binner_macros.svh.
`timescale 1ns / 1ps
`include "polar_scan_binner_macros.svh"
module psb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  psb_pkg::status_t sts,
  output psb_pkg::cmd_t   cmd
);

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b000_0000_0001,
    ST_IDLE  = 11'b000_0000_0010,
    ST_MUL   = 11'b000_0000_0100,
    ST_FIN   = 11'b000_0000_1000,
    ST_SQ    = 11'b000_0001_0000,
    ST_ITER  = 11'b000_0010_0000,
    ST_BIN   = 11'b000_0100_0000,
    ST_RDA   = 11'b000_1000_0000,
    ST_UPD   = 11'b001_0000_0000,
    ST_RD    = 11'b010_0000_0000,
    ST_RDW   = 11'b100_0000_0000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [psb_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                     in_xfer;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        if (cnt_r == psb_pkg::CNT_W'(psb_pkg::NUM_BINS - 1)) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt_r == psb_pkg::CNT_W'(3)) begin
          state_nxt = ST_FIN;
          cnt_nxt   = '0;
        end
      end
      ST_FIN: begin
        state_nxt = ST_SQ;
        cnt_nxt   = '0;
      end
      ST_SQ: begin
        if (cnt_r == psb_pkg::CNT_W'(1)) begin
          state_nxt = ST_ITER;
          cnt_nxt   = '0;
        end
      end
      ST_ITER: begin
        if (cnt_r == psb_pkg::CNT_W'(psb_pkg::SQRT_STEPS - 1)) begin
          state_nxt = ST_BIN;
          cnt_nxt   = '0;
        end
      end
      ST_BIN:  state_nxt = ST_RDA;
      ST_RDA:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_IDLE;
      ST_RD:   state_nxt = ST_RDW;
      ST_RDW: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // item register now holds the transferred item; pick the path from its op
    if ((state_r == ST_MUL) && (cnt_r == '0) && (sts.op == psb_pkg::OP_READ)) begin
      state_nxt = ST_RD;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.cnt     = cnt_r;
    cmd.clear   = (state_r == ST_CLEAR);
    cmd.load_in = in_xfer;
    cmd.mul     = (state_r == ST_MUL);
    cmd.fin     = (state_r == ST_FIN);
    cmd.sq      = (state_r == ST_SQ);
    cmd.iter    = (state_r == ST_ITER);
    cmd.bin     = (state_r == ST_BIN);
    cmd.mem_rd  = (state_r == ST_RDA) || (state_r == ST_RD);
    cmd.rd_sel  = (state_r == ST_RD);
    cmd.upd     = (state_r == ST_UPD);
    cmd.rd_done = (state_r == ST_RDW) && !sts.out_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `PSB_ASSERT_NEXT(a_xfer_leaves_idle, in_xfer, state_r == ST_MUL)
  `PSB_ASSERT(a_upd_after_read, (state_r == ST_UPD) |-> ($past(state_r) == ST_RDA))
  `PSB_ASSERT(a_state_onehot, $onehot(state_r))

endmodule

[rtl/core/psb_dp.sv]
// Datapath of the polar scan binner: transform, root, CORDIC, bin memory.
// Depends on psb_pkg and polar_scan_binner_macros.svh.
`timescale 1ns / 1ps
`include "polar_scan_binner_macros.svh"
module psb_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  psb_pkg::in_item_t   in_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output psb_pkg::out_item_t  out_item,
  input  psb_pkg::cmd_t       cmd,
  output psb_pkg::status_t    sts
);

  logic signed [15:0] rot_cos_r, rot_sin_r;
  logic signed [23:0] off_x_r, off_y_r;
  psb_pkg::in_item_t  item_r;

  logic signed [40:0] acc_x_r, acc_y_r;
  logic signed [27:0] tx_r, ty_r;
  logic [55:0]        sum_r, rad_r;
  logic [28:0]        rem_r;
  logic [27:0]        root_r;
  logic signed [31:0] cx_r, cy_r;
  logic signed [33:0] cz_r;
  logic               hold_r, keep_r;
  logic [psb_pkg::BIN_AW-1:0] idx_r;
  logic [23:0]        mem [psb_pkg::NUM_BINS];
  logic [23:0]        mem_q_r;
  psb_pkg::out_item_t out_r;
  logic               out_valid_r;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign sts.op       = item_r.operation;
  assign sts.out_busy = out_valid_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_cos_r <= 16'sd16384;
      rot_sin_r <= '0;
      off_x_r   <= '0;
      off_y_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        psb_pkg::CFG_ROT_COS:  rot_cos_r <= cfg_data[15:0];
        psb_pkg::CFG_ROT_SIN:  rot_sin_r <= cfg_data[15:0];
        psb_pkg::CFG_OFFSET_X: off_x_r   <= cfg_data;
        psb_pkg::CFG_OFFSET_Y: off_y_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // rotation products, one per cycle
  logic signed [15:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [39:0] prod;
  always_comb begin
    mul_a = cmd.cnt[0] ^ cmd.cnt[1] ? rot_sin_r : rot_cos_r;
    mul_b = cmd.cnt[0] ? item_r.point_y : item_r.point_x;
    prod  = mul_a * mul_b;
  end

  logic signed [41:0] rnd_x, rnd_y;
  assign rnd_x = 42'(acc_x_r) + 42'sd8192;
  assign rnd_y = 42'(acc_y_r) + 42'sd8192;

  // squares of the magnitudes
  logic [27:0] ax, ay, sq_op;
  logic [55:0] sq;
  assign ax    = 28'(tx_r[27] ? -tx_r : tx_r);
  assign ay    = 28'(ty_r[27] ? -ty_r : ty_r);
  assign sq_op = cmd.cnt[0] ? ay : ax;
  assign sq    = 56'(sq_op) * 56'(sq_op);

  // restoring square root, one result bit per step
  logic [55:0] rad_src;
  logic [28:0] rem_src;
  logic [27:0] root_src;
  logic [30:0] rem2, trial;
  logic        first;
  assign first    = (cmd.cnt == '0);
  assign rad_src  = first ? sum_r : rad_r;
  assign rem_src  = first ? '0 : rem_r;
  assign root_src = first ? '0 : root_r;
  assign rem2     = {rem_src, rad_src[55:54]};
  assign trial    = 31'({root_src, 2'b01});

  // CORDIC vectoring step
  logic [3:0]         sh;
  logic signed [31:0] dx, dy;
  logic signed [33:0] at;
  assign sh = cmd.cnt[3:0];
  assign dx = cy_r >>> sh;
  assign dy = cx_r >>> sh;
  assign at = psb_pkg::atan_lut(sh);

  // bin index from the angle
  logic signed [34:0] u;
  logic [46:0]        bprod;
  logic [14:0]        idx_w;
  assign u     = 35'(cz_r) + 35'sh080000000;
  assign bprod = 47'(u[33:0]) * 47'(psb_pkg::NUM_BINS);
  assign idx_w = bprod[46:32];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item_r <= in_item;
    end
    if (cmd.mul) begin
      unique case (cmd.cnt[1:0])
        2'd0: acc_x_r <= 41'(prod);
        2'd1: acc_x_r <= acc_x_r - 41'(prod);
        2'd2: acc_y_r <= 41'(prod);
        default: acc_y_r <= acc_y_r + 41'(prod);
      endcase
    end
    if (cmd.fin) begin
      tx_r <= 28'(rnd_x >>> 14) + 28'(off_x_r);
      ty_r <= 28'(rnd_y >>> 14) + 28'(off_y_r);
    end
    if (cmd.sq) begin
      sum_r <= cmd.cnt[0] ? sum_r + sq : sq;
      if (cmd.cnt[0] == 1'b0) begin
        hold_r <= (ty_r == '0);
        if (ty_r == '0) begin
          cz_r <= (tx_r > 0) ? '0 : psb_pkg::HALF_TURN;
        end else if (tx_r < 0) begin
          cx_r <= -(32'(tx_r));
          cy_r <= -(32'(ty_r));
          cz_r <= (ty_r > 0) ? psb_pkg::HALF_TURN : -psb_pkg::HALF_TURN;
        end else begin
          cx_r <= 32'(tx_r);
          cy_r <= 32'(ty_r);
          cz_r <= '0;
        end
      end
    end
    if (cmd.iter) begin
      rad_r <= {rad_src[53:0], 2'b00};
      if (rem2 >= trial) begin
        rem_r  <= 29'(rem2 - trial);
        root_r <= {root_src[26:0], 1'b1};
      end else begin
        rem_r  <= rem2[28:0];
        root_r <= {root_src[26:0], 1'b0};
      end
      if (!hold_r && (cmd.cnt < psb_pkg::CNT_W'(psb_pkg::CORDIC_STEPS))) begin
        if (cy_r > 0) begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          cz_r <= cz_r + at;
        end else begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          cz_r <= cz_r - at;
        end
      end
    end
    if (cmd.bin) begin
      keep_r <= !u[34] && (32'(idx_w) < psb_pkg::NUM_BINS)
                && (root_r >= psb_pkg::RANGE_LO) && (root_r <= psb_pkg::RANGE_HI);
      idx_r  <= psb_pkg::BIN_AW'(idx_w);
    end
  end

  // bin memory: one read and one write port
  logic                       req_ok;
  logic [psb_pkg::BIN_AW-1:0] req_addr, rd_addr, wr_addr;
  logic                       we;
  logic [23:0]                wd;
  assign req_ok   = (32'(item_r.bin_index) < psb_pkg::NUM_BINS);
  assign req_addr = psb_pkg::BIN_AW'(item_r.bin_index);
  assign rd_addr  = cmd.rd_sel ? req_addr : idx_r;

  always_comb begin
    we      = 1'b0;
    wr_addr = idx_r;
    wd      = psb_pkg::EMPTY_RANGE;
    priority if (cmd.clear) begin
      we      = 1'b1;
      wr_addr = psb_pkg::BIN_AW'(cmd.cnt);
    end else if (cmd.upd) begin
      we = keep_r && (root_r < 28'(mem_q_r));
      wd = root_r[23:0];
    end else if (cmd.rd_done) begin
      we      = req_ok;
      wr_addr = req_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wd;
    end
    if (cmd.mem_rd) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.rd_done) begin
      out_r.bin_range <= req_ok ? mem_q_r : psb_pkg::EMPTY_RANGE;
      out_r.bin_hit   <= req_ok && (mem_q_r != psb_pkg::EMPTY_RANGE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.rd_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  `PSB_ASSERT(a_out_from_read, $rose(out_valid_r) |-> $past(cmd.rd_done))
  `PSB_ASSERT(a_no_load_when_busy, cmd.rd_done |-> !out_valid_r)
  `PSB_ASSERT_NEXT(a_out_holds, out_valid_r && !out_ready, out_valid_r && $stable(out_r))

endmodule

[rtl/core/polar_scan_binner.sv]
// Top level of the polar scan binner: controller plus datapath.
// Depends on psb_pkg, psb_ctrl and psb_dp.
//
//   channel | ports                           | payload
//   in      | in_valid / in_ready             | in_item (psb_pkg::in_item_t)
//   out     | out_valid / out_ready           | out_item (psb_pkg::out_item_t)
//   cfg     | cfg_valid / cfg_ready           | cfg_index, cfg_data
//
// An add transfer runs from acceptance to the next in_ready through four
// rotation products on one 16x24 multiplier, two squares, then 28 steps of the
// bit-serial square root (the 16 CORDIC steps run beside it) and a bin update.
// A read transfer reads the requested bin and empties it when the result loads.
// After reset a clearing pass empties every one of the NUM_BINS (720) bins;
// in_ready stays low meanwhile, configuration writes are taken at any time.
// A stalled result holds in its register; a new add is taken meanwhile, and a
// new read waits in the controller until the result is taken.
`timescale 1ns / 1ps
module polar_scan_binner (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  psb_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output psb_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  psb_pkg::cmd_t    cmd;
  psb_pkg::status_t sts;

  // sequencer: owns the state and the step counter
  psb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic, bin memory and result register
  psb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[tb/polar_scan_binner_test.sv]
// Self-checking testbench of the polar scan binner: directed table then random traffic.
// Depends on psb_pkg and polar_scan_binner; predicts bins with its own fixed-point model.
`timescale 1ns / 1ps
module polar_scan_binner_test;

  localparam logic [7:0] CFG_UNMAPPED = 8'd4;
  localparam int EMPTY_Q = int'(psb_pkg::EMPTY_RANGE);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  psb_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  psb_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  polar_scan_binner u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: transform registers and the bin minimums.
  longint cos_q, sin_q, off_x, off_y;
  logic [23:0] bin_min [psb_pkg::NUM_BINS];
  psb_pkg::out_item_t pending_reads[$];
  int errors = 0;
  bit quiet_out = 1'b0;   // long stretch with no idling on either side
  int hold_off = 0;       // receiver backpressure cycles still to serve

  localparam longint ATAN_TAB [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861};

  function automatic longint fl_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  task automatic bin_point(input longint px, input longint py);
    longint tx, ty, r, x, y, z, u, dx, dy, idx;
    tx = fl_shift(cos_q * px - sin_q * py + 8192, 14) + off_x;
    ty = fl_shift(sin_q * px + cos_q * py + 8192, 14) + off_y;
    r = int_sqrt(tx * tx + ty * ty);
    if (r < 1966 || r > 655360) return;
    if (ty == 0) begin
      z = (tx > 0) ? 0 : 64'sd2147483648;
    end else begin
      x = tx;
      y = ty;
      z = 0;
      if (tx < 0) begin
        z = (ty > 0) ? 64'sd2147483648 : -64'sd2147483648;
        x = -tx;
        y = -ty;
      end
      for (int i = 0; i < 16; i++) begin
        dx = fl_shift(y, i);
        dy = fl_shift(x, i);
        if (y > 0) begin
          x += dx; y -= dy; z += ATAN_TAB[i];
        end else begin
          x -= dx; y += dy; z -= ATAN_TAB[i];
        end
      end
    end
    u = z + 64'sd2147483648;
    if (u < 0) return;
    idx = (u * psb_pkg::NUM_BINS) >>> 32;
    if (idx >= psb_pkg::NUM_BINS) return;
    if (r[23:0] < bin_min[idx]) bin_min[idx] = r[23:0];
  endtask

  function automatic psb_pkg::out_item_t read_bin(input logic [9:0] bi);
    psb_pkg::out_item_t o;
    if (bi >= psb_pkg::NUM_BINS) begin
      o.bin_range = psb_pkg::EMPTY_RANGE;
      o.bin_hit = 1'b0;
    end else begin
      o.bin_range = bin_min[bi];
      o.bin_hit = (bin_min[bi] != psb_pkg::EMPTY_RANGE);
      bin_min[bi] = psb_pkg::EMPTY_RANGE;
    end
    return o;
  endfunction

  // Send one item; reads queue the predicted (or typed-in) result.
  // Valid stays high between back-to-back items; drop it only to idle.
  task automatic send_item(input psb_pkg::in_item_t it, input bit has_fixed,
                           input psb_pkg::out_item_t fixed);
    psb_pkg::out_item_t o;
    bit idle;
    idle = !quiet_out && ($urandom_range(99) < 10);
    if (idle) in_valid <= 1'b0;
    while (idle) begin
      @(posedge clk);
      idle = !quiet_out && ($urandom_range(99) < 10);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    if (it.operation == psb_pkg::OP_ADD) begin
      bin_point(longint'(it.point_x), longint'(it.point_y));
    end else begin
      o = read_bin(it.bin_index);
      pending_reads.insert(pending_reads.size(), has_fixed ? fixed : o);
    end
  endtask

  // Valid stays high between back-to-back writes; the caller drops it.
  task automatic write_reg(input logic [7:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      psb_pkg::CFG_ROT_COS:  cos_q = longint'($signed(val[15:0]));
      psb_pkg::CFG_ROT_SIN:  sin_q = longint'($signed(val[15:0]));
      psb_pkg::CFG_OFFSET_X: off_x = longint'($signed(val));
      psb_pkg::CFG_OFFSET_Y: off_y = longint'($signed(val));
      default: ;
    endcase
  endtask

  // Drain outstanding reads, then let a trailing add finish.
  task automatic settle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_reads.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  // Receive side: random stalls, plus a counted hold-off on request.
  always @(posedge clk) begin
    psb_pkg::out_item_t exp_o;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_reads.size() == 0) begin
          $error("result transfer with no read outstanding");
          errors++;
        end else begin
          exp_o = pending_reads.pop_front();
          if (out_item.bin_range !== exp_o.bin_range) begin
            $error("bin_range expected %0d actual %0d", exp_o.bin_range, out_item.bin_range);
            errors++;
          end
          if (out_item.bin_hit !== exp_o.bin_hit) begin
            $error("bin_hit expected %0d actual %0d", exp_o.bin_hit, out_item.bin_hit);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet_out || ($urandom_range(99) >= 10);
      end
    end
  end

  function automatic psb_pkg::in_item_t mk(input logic op, input int x, input int y,
                                           input int bi);
    psb_pkg::in_item_t it;
    it.operation = op;
    it.point_x = x[23:0];
    it.point_y = y[23:0];
    it.bin_index = bi[9:0];
    return it;
  endfunction

  typedef struct {
    psb_pkg::in_item_t   item;
    bit                  has_fixed;
    psb_pkg::out_item_t  fixed;
  } stim_row_t;

  stim_row_t dir[$];

  function automatic stim_row_t row(input psb_pkg::in_item_t it, input bit hf, input int rng,
                                    input bit hit);
    stim_row_t s;
    s.item = it;
    s.has_fixed = hf;
    s.fixed.bin_range = rng[23:0];
    s.fixed.bin_hit = hit;
    return s;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(input stim_row_t s);
    dir.insert(dir.size(), s);
  endfunction

  // Random add: mostly points within sensing range, sometimes any value.
  function automatic psb_pkg::in_item_t rand_add();
    int x, y;
    if ($urandom_range(9) < 8) begin
      x = int'($urandom_range(1310720)) - 655360;
      y = int'($urandom_range(1310720)) - 655360;
    end else begin
      x = int'($urandom);
      y = int'($urandom);
    end
    return mk(psb_pkg::OP_ADD, x, y, int'($urandom));
  endfunction

  function automatic psb_pkg::in_item_t rand_read();
    int bi;
    bi = ($urandom_range(19) == 0) ? int'($urandom_range(1023))
                                   : int'($urandom_range(psb_pkg::NUM_BINS - 1));
    return mk(psb_pkg::OP_READ, int'($urandom), int'($urandom), bi);
  endfunction

  initial begin
    psb_pkg::out_item_t none;
    int cfg_sets [5][4];
    none = '0;
    cos_q = 16384; sin_q = 0; off_x = 0; off_y = 0;
    for (int i = 0; i < psb_pkg::NUM_BINS; i++) bin_min[i] = psb_pkg::EMPTY_RANGE;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty reads, range limits, axis cases, field extremes, bad index.
    add_row(row(mk(psb_pkg::OP_READ, 0, 0, 0), 1, EMPTY_Q, 0));
    add_row(row(mk(psb_pkg::OP_READ, 0, 0, 719), 1, EMPTY_Q, 0));
    add_row(row(mk(psb_pkg::OP_READ, -1, -1, 1023), 1, EMPTY_Q, 0));
    add_row(row(mk(psb_pkg::OP_READ, 0, 0, 720), 1, EMPTY_Q, 0));
    add_row(row(mk(psb_pkg::OP_ADD, 65536, 0, 0), 0, 0, 0));       // angle 0
    add_row(row(mk(psb_pkg::OP_READ, 0, 0, 360), 1, 65536, 1));
    add_row(row(mk(psb_pkg::OP_READ, 0, 0, 360), 1, EMPTY_Q, 0));
    add_row(row(mk(psb_pkg::OP_ADD, 1966, 0, 0), 0, 0, 0));        // lower limit kept
    add_row(row(mk(psb_pkg::OP_ADD, 1965, 0, 0), 0, 0, 0));        // below limit
    add_row(row(mk(psb_pkg::OP_READ, 0, 0, 360), 1, 1966, 1));
    add_row(row(mk(psb_pkg::OP_ADD, 655360, 0, 0), 0, 0, 0));      // upper limit kept
    add_row(row(mk(psb_pkg::OP_ADD, 655361, 0, 0), 0, 0, 0));
    add_row(row(mk(psb_pkg::OP_READ, 0, 0, 360), 1, 655360, 1));
    add_row(row(mk(psb_pkg::OP_ADD, -65536, 0, 0), 0, 0, 0));      // +pi, dropped
    add_row(row(mk(psb_pkg::OP_READ, 0, 0, 0), 1, EMPTY_Q, 0));
    add_row(row(mk(psb_pkg::OP_ADD, -65536, -1, 0), 0, 0, 0));     // just below -x axis
    add_row(row(mk(psb_pkg::OP_ADD, -65536, 1, 0), 0, 0, 0));
    add_row(row(mk(psb_pkg::OP_ADD, 0, 65536, 0), 0, 0, 0));
    add_row(row(mk(psb_pkg::OP_ADD, 0, -65536, 0), 0, 0, 0));
    add_row(row(mk(psb_pkg::OP_ADD, 8388607, 8388607, 0), 0, 0, 0));
    add_row(row(mk(psb_pkg::OP_ADD, -8388608, -8388608, 0), 0, 0, 0));
    add_row(row(mk(psb_pkg::OP_READ, 0, 0, 0), 0, 0, 0));
    add_row(row(mk(psb_pkg::OP_READ, 0, 0, 719), 0, 0, 0));
    add_row(row(mk(psb_pkg::OP_READ, 0, 0, 180), 0, 0, 0));
    add_row(row(mk(psb_pkg::OP_READ, 0, 0, 540), 0, 0, 0));
    foreach (dir[i]) send_item(dir[i].item, dir[i].has_fixed, dir[i].fixed);
    settle();

    // Register settings: identity, extremes, and a rotated, shifted frame.
    cfg_sets = '{'{-16384, 0, 8388607, -8388608},
                 '{0, 16384, 0, 0},
                 '{0, -16384, 65536, -131072},
                 '{11585, 11585, -200000, 150000},
                 '{16384, 0, 0, 0}};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(psb_pkg::CFG_ROT_COS, 24'(cfg_sets[ph][0]));
      write_reg(psb_pkg::CFG_ROT_SIN, 24'(cfg_sets[ph][1]));
      write_reg(psb_pkg::CFG_OFFSET_X, 24'(cfg_sets[ph][2]));
      write_reg(psb_pkg::CFG_OFFSET_Y, 24'(cfg_sets[ph][3]));
      if (ph == 0) write_reg(CFG_UNMAPPED, 24'hABCDEF);  // unmapped index, ignored
      cfg_valid <= 1'b0;
      quiet_out = (ph == 2);
      for (int n = 0; n < 365; n++) begin
        if (ph == 1 && n == 50) hold_off = 400;  // backpressure while sending
        if ($urandom_range(9) < 6) send_item(rand_add(), 0, none);
        else send_item(rand_read(), 0, none);
      end
      settle();
    end

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
